@@ src/ast_pkg.sv @@
// ----------------------------------------------------------------------------
// ast_pkg
// shared types and codes of the aggregation slot tracker: actions, register
// indexes, the sequencer states, the slot row layout and the remainder unit
// request and response
// ----------------------------------------------------------------------------
package ast_pkg;

  localparam int SEEN_W = 32;
  localparam int CNT_W  = 7;
  localparam int FAN_W  = 6;

  typedef enum logic [1:0] {
    ACT_DROP  = 2'd0,
    ACT_UP    = 2'd1,
    ACT_DOWN  = 2'd2,
    ACT_REPLY = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_NUM_WORKERS = 2'd0,
    REG_FAN_IN      = 2'd1,
    REG_TOP_LEVEL   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_MODW,
    S_MODF,
    S_EMIT
  } state_t;

  // one memory row holds both versions of a slot
  typedef struct packed {
    logic [1:0][CNT_W-1:0]  cnt;
    logic [1:0][SEEN_W-1:0] seen;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic             start;
    logic [CNT_W:0]   dividend;
    logic [CNT_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] rem;
  } mod_rsp_t;

endpackage

@@ src/aggregation_slot_tracker.sv @@
// ----------------------------------------------------------------------------
// aggregation_slot_tracker
// update tracking of one in-network aggregation switch: per slot and version
// a bitmap of children seen and an update count, held in one ram row per slot
// ----------------------------------------------------------------------------
// Each beat in gives exactly one beat out. The slot state lives in one ram
// with a row per slot (both versions), read as the beat is taken so that the
// row is ready in the look-up state, and written back when the result is
// handed to the output register, so one beat is in flight at a time. A
// downward packet, a duplicate or a dropped packet goes from acceptance
// through look-up and emit back to idle; a new upward update also has its
// count go twice through the single remainder unit, first by worker count,
// then by fan-in. After reset a clearing pass writes every row to zero, one
// row a cycle; in_ready stays low meanwhile while register writes are taken
// as usual. A result waiting in the output register does not stop the next
// beat from being accepted and looked up.
// ----------------------------------------------------------------------------
module aggregation_slot_tracker #(
  parameter int NUM_SLOTS    = 256,
  parameter int MAX_CHILDREN = 32,
  parameter int MAX_WORKERS  = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_is_upward,
  input  logic [7:0]       in_slot,
  input  logic             in_version,
  input  logic [4:0]       in_sender_id,
  output logic             out_valid,
  input  logic             out_ready,
  output ast_pkg::action_t out_action,
  output logic [4:0]       out_dest_id,
  output logic [7:0]       out_slot,
  output logic             out_version,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ast_pkg::*;

  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [CNT_W-1:0] W_CAP = CNT_W'((MAX_WORKERS > 127) ? 127 : MAX_WORKERS);

  // configuration
  logic [CNT_W-1:0] num_workers_r;
  logic [FAN_W-1:0] fan_in_r;
  logic             top_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;
  logic [CNT_W-1:0] eff_w;
  logic [CNT_W-1:0] w_lo;
  logic [FAN_W-1:0] eff_f;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_workers_r <= CNT_W'(1);
      fan_in_r      <= FAN_W'(1);
      top_r         <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_NUM_WORKERS: num_workers_r <= pwdata[CNT_W-1:0];
        REG_FAN_IN:      fan_in_r      <= pwdata[FAN_W-1:0];
        REG_TOP_LEVEL:   top_r         <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_NUM_WORKERS: prdata = {25'd0, num_workers_r};
      REG_FAN_IN:      prdata = {26'd0, fan_in_r};
      REG_TOP_LEVEL:   prdata = {31'd0, top_r};
      default:         prdata = '0;
    endcase
  end

  assign w_lo  = (num_workers_r == '0) ? CNT_W'(1) : num_workers_r;
  assign eff_w = (w_lo > W_CAP) ? W_CAP : w_lo;
  assign eff_f = (fan_in_r == '0) ? FAN_W'(1) : fan_in_r;

  // sequencer
  state_t           state_r, state_nxt;
  logic [AW-1:0]    clr_idx_r;
  logic             clr_last;
  logic             in_fire;
  logic             out_free;
  logic             emit_fire;

  logic             it_up_r;
  logic [7:0]       it_slot_r;
  logic             it_ver_r;
  logic [4:0]       it_sender_r;
  logic             it_slot_ok_r;
  logic             it_snd_ok_r;
  logic [AW-1:0]    it_addr_r;

  row_t             rd_row;
  row_t             row_r;
  logic             wr_en_r;
  action_t          res_action_r;
  logic [4:0]       res_dest_r;
  logic [7:0]       res_slot_r;
  logic             res_ver_r;

  logic             out_valid_r;
  action_t          out_action_r;
  logic [4:0]       out_dest_r;
  logic [7:0]       out_slot_r;
  logic             out_ver_r;

  logic [AW+7:0]    slot_ext;
  logic [AW-1:0]    in_addr;
  logic             in_slot_ok;
  logic             in_snd_ok;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  row_t             ram_wdata;
  mod_req_t         mod_req;
  mod_rsp_t         mod_rsp;

  logic [CNT_W-1:0] cur_cnt;
  logic             is_dup;
  logic             is_new;
  row_t             upd_row;

  row_t             look_row;
  logic             look_wr;
  action_t          look_action;
  logic [4:0]       look_dest;
  logic [7:0]       look_slot;
  logic             look_ver;

  assign clr_last   = (clr_idx_r == AW'(NUM_SLOTS - 1));
  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign emit_fire  = (state_r == S_EMIT) && out_free;
  assign slot_ext   = {{AW{1'b0}}, in_slot};
  assign in_addr    = slot_ext[AW-1:0];
  assign in_slot_ok = (32'(in_slot) < NUM_SLOTS);
  assign in_snd_ok  = (32'(in_sender_id) < MAX_CHILDREN);

  assign cur_cnt = rd_row.cnt[it_ver_r];
  assign is_dup  = rd_row.seen[it_ver_r][it_sender_r];
  assign is_new  = it_slot_ok_r && it_up_r && it_snd_ok_r && !is_dup;

  always_comb begin
    upd_row = rd_row;
    upd_row.seen[it_ver_r][it_sender_r]  = 1'b1;
    upd_row.seen[!it_ver_r][it_sender_r] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_idx_r <= clr_idx_r + AW'(1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_LOOK;
      S_LOOK:  state_nxt = is_new ? S_MODW : S_EMIT;
      S_MODW:  if (mod_rsp.done) state_nxt = S_MODF;
      S_MODF:  if (mod_rsp.done) state_nxt = S_EMIT;
      S_EMIT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = it_addr_r;
    ram_wdata        = row_r;
    mod_req.start    = 1'b0;
    mod_req.dividend = {1'b0, cur_cnt} + (CNT_W + 1)'(1);
    mod_req.divisor  = eff_w;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        ram_wdata = '0;
      end
      S_IDLE: in_ready = 1'b1;
      S_LOOK: mod_req.start = is_new;
      S_MODW: begin
        mod_req.start    = mod_rsp.done;
        mod_req.dividend = {1'b0, mod_rsp.rem};
        mod_req.divisor  = {1'b0, eff_f};
      end
      S_MODF: ;
      S_EMIT: ram_we = out_free && wr_en_r;
      default: ;
    endcase
  end

  // decision on the looked-up row
  always_comb begin
    look_row    = rd_row;
    look_wr     = 1'b0;
    look_action = ACT_DROP;
    look_dest   = '0;
    look_slot   = '0;
    look_ver    = 1'b0;
    if (!it_slot_ok_r) begin
      look_action = ACT_DROP;
    end else if (!it_up_r) begin
      look_row.cnt[it_ver_r] = eff_w;
      look_wr     = 1'b1;
      look_action = ACT_DOWN;
      look_slot   = it_slot_r;
      look_ver    = it_ver_r;
    end else if (!it_snd_ok_r) begin
      look_action = ACT_DROP;
    end else if (is_dup) begin
      if (cur_cnt == eff_w) begin
        look_action = ACT_REPLY;
        look_dest   = it_sender_r;
        look_slot   = it_slot_r;
        look_ver    = it_ver_r;
      end else if (top_r && cur_cnt == '0) begin
        look_action = ACT_UP;
        look_slot   = it_slot_r;
        look_ver    = it_ver_r;
      end
    end else begin
      look_row = upd_row;
      look_wr  = 1'b1;
    end
  end

  // item capture and decision datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      it_up_r      <= in_is_upward;
      it_slot_r    <= in_slot;
      it_ver_r     <= in_version;
      it_sender_r  <= in_sender_id;
      it_slot_ok_r <= in_slot_ok;
      it_snd_ok_r  <= in_snd_ok;
      it_addr_r    <= in_addr;
    end
    if (state_r == S_LOOK) begin
      wr_en_r      <= look_wr;
      res_action_r <= look_action;
      res_dest_r   <= look_dest;
      res_slot_r   <= look_slot;
      res_ver_r    <= look_ver;
      row_r        <= look_row;
    end else if (state_r == S_MODF && mod_rsp.done) begin
      if (mod_rsp.rem != '0) begin
        row_r.cnt[it_ver_r] <= mod_rsp.rem;
        res_action_r        <= ACT_DROP;
      end else if (top_r) begin
        row_r.cnt[it_ver_r] <= eff_w;
        res_action_r        <= ACT_DOWN;
        res_slot_r          <= it_slot_r;
        res_ver_r           <= it_ver_r;
      end else begin
        row_r.cnt[it_ver_r] <= '0;
        res_action_r        <= ACT_UP;
        res_slot_r          <= it_slot_r;
        res_ver_r           <= it_ver_r;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_action_r <= res_action_r;
      out_dest_r   <= res_dest_r;
      out_slot_r   <= res_slot_r;
      out_ver_r    <= res_ver_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_action  = out_action_r;
  assign out_dest_id = out_dest_r;
  assign out_slot    = out_slot_r;
  assign out_version = out_ver_r;

  ast_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SLOTS),
    .AW    (AW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (in_addr),
    .rdata (rd_row)
  );

  ast_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready) else $error("beat taken during clearing pass");

  a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_LOOK)) else $error("accepted beat not looked up");

  a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_action_r == ACT_DROP) |->
      (out_dest_r == '0 && out_slot_r == '0 && !out_ver_r))
    else $error("dropped beat carries payload");

  a_write_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r != S_CLEAR) |=> out_valid_r)
    else $error("row written without a result");

endmodule

@@ src/ast_ram.sv @@
// ----------------------------------------------------------------------------
// ast_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module ast_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/ast_mod_unit.sv @@
// ----------------------------------------------------------------------------
// ast_mod_unit
// restoring remainder unit, one quotient bit per cycle, eight iterations, the
// result and its done flag appear after the last iteration
// ----------------------------------------------------------------------------
module ast_mod_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  ast_pkg::mod_req_t req,
  output ast_pkg::mod_rsp_t rsp
);
  import ast_pkg::*;

  logic [CNT_W:0]   div_r;
  logic [CNT_W-1:0] d_r;
  logic [CNT_W-1:0] rem_r;
  logic [2:0]       step_r;
  logic             busy_r;
  logic             done_r;
  logic [CNT_W:0]   trial;

  assign trial = {rem_r, div_r[CNT_W]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (req.start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        step_r <= 3'd7;
        div_r  <= req.dividend;
        d_r    <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        if (trial >= {1'b0, d_r}) begin
          rem_r <= CNT_W'(trial - {1'b0, d_r});
        end else begin
          rem_r <= trial[CNT_W-1:0];
        end
        div_r <= {div_r[CNT_W-1:0], 1'b0};
        if (step_r == 3'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 3'd1;
          done_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.start && busy_r)) else $error("remainder unit restarted while busy");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> ##9 done_r) else $error("remainder unit latency wrong");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < d_r)) else $error("remainder not below divisor");

endmodule

@@ verif/aggregation_slot_tracker_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aggregation_slot_tracker_tb
// self-checking bench for the aggregation slot tracker: a short scripted run
// of corner packets and register writes, then aggregation rounds over a small
// pool of slots mixed with random packets, in six register settings and three
// idling modes; decisions are checked against the script or an in-bench tracker
// ----------------------------------------------------------------------------
module aggregation_slot_tracker_tb;

  import ast_pkg::*;

  localparam int MAX_WORKERS = 64;
  localparam int PHASES      = 6;
  localparam int PHASE_BEATS = 334;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    action_t    action;
    logic [4:0] dest;
    logic [7:0] slot;
    logic       ver;
  } decision_t;

  typedef struct {
    bit          is_cfg;
    reg_idx_t    reg_sel;
    logic [31:0] value;
    bit          up;
    bit [7:0]    slot;
    bit          ver;
    bit [4:0]    sender;
    bit          typed;
    decision_t   want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_is_upward = 1'b0;
  logic [7:0]  in_slot = '0;
  logic        in_version = 1'b0;
  logic [4:0]  in_sender_id = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  action_t     out_action;
  logic [4:0]  out_dest_id;
  logic [7:0]  out_slot;
  logic        out_version;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  aggregation_slot_tracker uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_is_upward (in_is_upward),
    .in_slot      (in_slot),
    .in_version   (in_version),
    .in_sender_id (in_sender_id),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_action   (out_action),
    .out_dest_id  (out_dest_id),
    .out_slot     (out_slot),
    .out_version  (out_version),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // tracker shadow: index is slot*2 + version
  logic [31:0] slot_seen [512];
  logic [6:0]  slot_count [512];
  logic [6:0]  cfg_workers = 7'd1;
  logic [5:0]  cfg_fan_in = 6'd1;
  logic        cfg_top = 1'b0;

  decision_t   expected_decisions [$];
  script_row_t script [$];
  int          mismatches = 0;
  int          phase_beats = 0;
  int          src_gap_pct = 0;
  int          sink_gap_pct = 0;
  int          quiet_cycles = 0;

  initial begin
    foreach (slot_seen[i]) begin
      slot_seen[i] = '0;
      slot_count[i] = '0;
    end
  end

  function automatic int eff_workers();
    if (cfg_workers == 0) return 1;
    if (cfg_workers > MAX_WORKERS) return MAX_WORKERS;
    return int'(cfg_workers);
  endfunction

  function automatic int eff_fan_in();
    return (cfg_fan_in == 0) ? 1 : int'(cfg_fan_in);
  endfunction

  function automatic decision_t decide_packet(bit up, bit [7:0] slot, bit ver,
                                              bit [4:0] sender);
    decision_t   d;
    int          idx;
    int          other;
    int          w;
    int          c;
    logic [31:0] mask;
    d = '{action: ACT_DROP, dest: 5'd0, slot: 8'd0, ver: 1'b0};
    w = eff_workers();
    idx = int'({slot, ver});
    other = int'({slot, ~ver});
    if (!up) begin
      slot_count[idx] = 7'(w);
      d = '{action: ACT_DOWN, dest: 5'd0, slot: slot, ver: ver};
      return d;
    end
    mask = 32'd1 << sender;
    c = int'(slot_count[idx]);
    if ((slot_seen[idx] & mask) != 0) begin
      if (c == w)
        d = '{action: ACT_REPLY, dest: sender, slot: slot, ver: ver};
      else if (cfg_top && c == 0)
        d = '{action: ACT_UP, dest: 5'd0, slot: slot, ver: ver};
      return d;
    end
    slot_seen[idx] = slot_seen[idx] | mask;
    slot_seen[other] = slot_seen[other] & ~mask;
    c = ((c + 1) % w) % eff_fan_in();
    slot_count[idx] = 7'(c);
    if (c == 0) begin
      if (cfg_top) begin
        slot_count[idx] = 7'(w);
        d = '{action: ACT_DOWN, dest: 5'd0, slot: slot, ver: ver};
      end else begin
        d = '{action: ACT_UP, dest: 5'd0, slot: slot, ver: ver};
      end
    end
    return d;
  endfunction

  function automatic script_row_t pkt(bit up, bit [7:0] slot, bit ver, bit [4:0] sender);
    script_row_t r;
    r = '{is_cfg: 1'b0, reg_sel: REG_NUM_WORKERS, value: '0, up: up, slot: slot,
          ver: ver, sender: sender, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic script_row_t pkt_want(bit up, bit [7:0] slot, bit ver, bit [4:0] sender,
                                           action_t a, bit [4:0] dest, bit [7:0] oslot,
                                           bit over);
    script_row_t r;
    r = pkt(up, slot, ver, sender);
    r.typed = 1'b1;
    r.want = '{action: a, dest: dest, slot: oslot, ver: over};
    return r;
  endfunction

  function automatic script_row_t reg_row(reg_idx_t sel, logic [31:0] value);
    script_row_t r;
    r = pkt(1'b0, 8'd0, 1'b0, 5'd0);
    r.is_cfg = 1'b1;
    r.reg_sel = sel;
    r.value = value;
    return r;
  endfunction

  task automatic send_beat(bit up, bit [7:0] slot, bit ver, bit [4:0] sender,
                           bit typed, decision_t typed_want);
    decision_t predicted;
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_is_upward <= up;
    in_slot      <= slot;
    in_version   <= ver;
    in_sender_id <= sender;
    do @(posedge clk); while (!in_ready);
    predicted = decide_packet(up, slot, ver, sender);
    expected_decisions.push_back(typed ? typed_want : predicted);
    phase_beats++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_decisions.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(reg_idx_t sel, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel)
      REG_NUM_WORKERS: cfg_workers = value[6:0];
      REG_FAN_IN:      cfg_fan_in = value[5:0];
      default:         cfg_top = value[0];
    endcase
    @(posedge clk);
  endtask

  // distinct senders into one slot version, then duplicates and maybe the result
  task automatic aggregation_round();
    int       ids [32];
    int       n;
    int       k;
    int       j;
    int       tmp;
    int       c;
    bit [7:0] s;
    bit       v;
    s = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
    v = 1'($urandom_range(1));
    n = 32;
    c = 0;
    for (k = 1; k <= 32; k++) begin
      c = ((c + 1) % eff_workers()) % eff_fan_in();
      if (c == 0 && n == 32) n = k;
    end
    if ($urandom_range(3) == 0) n = $urandom_range(1, 32);
    for (k = 0; k < 32; k++) ids[k] = k;
    for (k = 31; k > 0; k--) begin
      j = $urandom_range(k);
      tmp = ids[k];
      ids[k] = ids[j];
      ids[j] = tmp;
    end
    for (k = 0; k < n; k++) send_beat(1'b1, s, v, 5'(ids[k]), 1'b0, '0);
    if ($urandom_range(1) == 1)
      repeat ($urandom_range(1, 3))
        send_beat(1'b1, s, v, 5'(ids[$urandom_range(n - 1)]), 1'b0, '0);
    if ($urandom_range(1) == 1) send_beat(1'b0, s, v, 5'($urandom_range(31)), 1'b0, '0);
    repeat ($urandom_range(2))
      send_beat(1'b1, s, v, 5'(ids[$urandom_range(n - 1)]), 1'b0, '0);
  endtask

  int phase_workers [PHASES] = '{4, 8, 64, 0, 127, 5};
  int phase_fan_in  [PHASES] = '{4, 3, 32, 0, 63, 2};
  int phase_top     [PHASES] = '{0, 1, 1, 0, 1, 0};

  initial begin
    // reset settings: one worker, fan-in one, not top level
    script.push_back(pkt_want(1'b1, 8'd0, 1'b0, 5'd0, ACT_UP, 5'd0, 8'd0, 1'b0));
    script.push_back(pkt_want(1'b1, 8'd0, 1'b0, 5'd0, ACT_DROP, 5'd0, 8'd0, 1'b0));
    script.push_back(pkt_want(1'b0, 8'd0, 1'b0, 5'd0, ACT_DOWN, 5'd0, 8'd0, 1'b0));
    script.push_back(pkt_want(1'b1, 8'd0, 1'b0, 5'd0, ACT_REPLY, 5'd0, 8'd0, 1'b0));
    script.push_back(pkt_want(1'b1, 8'd255, 1'b1, 5'd31, ACT_UP, 5'd0, 8'd255, 1'b1));
    script.push_back(pkt(1'b1, 8'd255, 1'b0, 5'd31));
    script.push_back(pkt(1'b1, 8'd255, 1'b1, 5'd31));
    script.push_back(pkt_want(1'b0, 8'd255, 1'b1, 5'd31, ACT_DOWN, 5'd0, 8'd255, 1'b1));
    script.push_back(reg_row(REG_TOP_LEVEL, 32'd1));
    // sender cleared from the other version counts again and wraps down at the top
    script.push_back(pkt_want(1'b1, 8'd255, 1'b0, 5'd31, ACT_DOWN, 5'd0, 8'd255, 1'b0));
    script.push_back(pkt_want(1'b1, 8'd7, 1'b0, 5'd5, ACT_DOWN, 5'd0, 8'd7, 1'b0));
    script.push_back(pkt_want(1'b1, 8'd7, 1'b0, 5'd5, ACT_REPLY, 5'd5, 8'd7, 1'b0));
    script.push_back(reg_row(REG_NUM_WORKERS, 32'd3));
    script.push_back(reg_row(REG_FAN_IN, 32'd2));
    script.push_back(pkt_want(1'b1, 8'd9, 1'b1, 5'd1, ACT_DROP, 5'd0, 8'd0, 1'b0));
    script.push_back(pkt(1'b1, 8'd9, 1'b1, 5'd2));
    script.push_back(pkt(1'b1, 8'd9, 1'b1, 5'd1));
    // worker count above the maximum is clamped, zero fan-in acts as one
    script.push_back(reg_row(REG_NUM_WORKERS, 32'd127));
    script.push_back(reg_row(REG_FAN_IN, 32'd0));
    script.push_back(pkt(1'b1, 8'd10, 1'b0, 5'd3));
    script.push_back(pkt_want(1'b1, 8'd10, 1'b0, 5'd3, ACT_REPLY, 5'd3, 8'd10, 1'b0));
    // zero workers acts as one
    script.push_back(reg_row(REG_NUM_WORKERS, 32'd0));
    script.push_back(reg_row(REG_FAN_IN, 32'd63));
    script.push_back(reg_row(REG_TOP_LEVEL, 32'd0));
    script.push_back(pkt_want(1'b1, 8'd11, 1'b1, 5'd30, ACT_UP, 5'd0, 8'd11, 1'b1));
    script.push_back(pkt_want(1'b1, 8'd11, 1'b1, 5'd30, ACT_DROP, 5'd0, 8'd0, 1'b0));
    script.push_back(reg_row(REG_NUM_WORKERS, 32'd64));
    script.push_back(reg_row(REG_FAN_IN, 32'd32));
    script.push_back(pkt(1'b1, 8'd12, 1'b0, 5'd0));
    script.push_back(pkt(1'b0, 8'd12, 1'b0, 5'd17));
    script.push_back(pkt(1'b1, 8'd12, 1'b0, 5'd0));
    script.push_back(pkt(1'b1, 8'd12, 1'b0, 5'd1));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        settle();
        apb_write(script[i].reg_sel, script[i].value);
      end else begin
        send_beat(script[i].up, script[i].slot, script[i].ver, script[i].sender,
                  script[i].typed, script[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p / 2)
        0: begin
          src_gap_pct = 37;
          sink_gap_pct = 47;
        end
        1: begin
          src_gap_pct = 47;
          sink_gap_pct = 37;
        end
        default: begin
          src_gap_pct = 0;
          sink_gap_pct = 0;
        end
      endcase
      settle();
      apb_write(REG_NUM_WORKERS, phase_workers[p]);
      apb_write(REG_FAN_IN, phase_fan_in[p]);
      apb_write(REG_TOP_LEVEL, phase_top[p]);
      phase_beats = 0;
      while (phase_beats < PHASE_BEATS) begin
        if ($urandom_range(99) < 70)
          aggregation_round();
        else
          send_beat(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                    5'($urandom_range(31)), 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0 && expected_decisions.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  always @(posedge clk) begin : result_check
    decision_t got;
    decision_t want;
    got = '{action: out_action, dest: out_dest_id, slot: out_slot, ver: out_version};
    if (rst_n && out_valid && out_ready) begin
      if (expected_decisions.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected beat: action %0d dest %0d slot %0d ver %0d",
                   got.action, got.dest, got.slot, got.ver);
        mismatches++;
      end else begin
        want = expected_decisions.pop_front();
        if (got !== want) begin
          if (mismatches < 10)
            $display("beat mismatch: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     want.action, want.dest, want.slot, want.ver,
                     got.action, got.dest, got.slot, got.ver);
          mismatches++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= sink_gap_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
